// ===== src/fpl_pkg.sv =====
// Shared types and constants for the priority-level queue.
package fpl_pkg;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int PRI_W    = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int CAP_W    = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQ,
        ACT_DEQ,
        ACT_DEQ_PRI,
        ACT_PEEK
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_BADPRI
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_READ
    } fsm_t;

endpackage

// ===== src/fpl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/fifo_with_priority_levels.sv =====
// Top level: priority queue, first-in first-out within each level; plain dequeue takes
// the oldest entry overall. Flow: on acceptance the value RAM is read and the result
// fields are captured; in the read state the result is registered on the output once
// the output register is free. No new item is accepted until that result is loaded.
// Reset: occupancy, level counts, slot flags, capacity and the output valid flag are
// cleared; RAM content is left as is, and an unwritten entry is never output.
module fifo_with_priority_levels #(
    parameter int STORE_DEPTH = 16,
    parameter int LEVEL_COUNT = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fpl_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fpl_pkg::ACTION_W-1:0]  s_action,
    input  logic signed [fpl_pkg::VALUE_W-1:0] s_value,
    input  logic [fpl_pkg::PRI_W-1:0]     s_priority_req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fpl_pkg::STATUS_W-1:0]  m_status,
    output logic signed [fpl_pkg::VALUE_W-1:0] m_data_out,
    output logic [fpl_pkg::OCC_W-1:0]     m_occupancy
);

    localparam int IDX_W   = $clog2(STORE_DEPTH);
    localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
    localparam int LVL_W   = $clog2(LEVEL_COUNT);
    localparam int LIM_W   = (COUNT_W > fpl_pkg::CAP_W) ? COUNT_W : fpl_pkg::CAP_W;

    // Slot bookkeeping: live flag, level, age among all and age within the level
    logic [STORE_DEPTH-1:0] live_reg, live_next;
    logic [LVL_W-1:0]       lvl_reg   [STORE_DEPTH];
    logic [LVL_W-1:0]       lvl_next  [STORE_DEPTH];
    logic [IDX_W-1:0]       grank_reg [STORE_DEPTH];
    logic [IDX_W-1:0]       grank_next[STORE_DEPTH];
    logic [IDX_W-1:0]       lrank_reg [STORE_DEPTH];
    logic [IDX_W-1:0]       lrank_next[STORE_DEPTH];
    logic [COUNT_W-1:0]     lcnt_reg  [LEVEL_COUNT];
    logic [COUNT_W-1:0]     lcnt_next [LEVEL_COUNT];
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [fpl_pkg::CAP_W-1:0] cap_reg;

    fpl_pkg::fsm_t    state_reg, state_next;
    fpl_pkg::status_t pst_reg, pst_next;
    logic             pzero_reg, pzero_next;
    logic [fpl_pkg::OCC_W-1:0] pocc_reg, pocc_next;

    logic                          m_valid_reg;
    fpl_pkg::status_t              m_status_reg;
    logic [fpl_pkg::VALUE_W-1:0]   m_data_reg;
    logic [fpl_pkg::OCC_W-1:0]     m_occ_reg;

    fpl_pkg::action_t   act;
    logic               accept, load_out;
    logic [LIM_W-1:0]   lim;
    logic               full, bad_pri, empty, enq_ok, do_remove;
    logic [LVL_W-1:0]   top_lvl, req_lvl, rem_lvl;
    logic [IDX_W-1:0]   sel_idx, free_idx, rem_grank, rem_lrank;
    logic [STORE_DEPTH-1:0] sel_hot;
    logic [fpl_pkg::VALUE_W-1:0] ram_rdata;

    assign act      = fpl_pkg::action_t'(s_action);
    assign s_ready  = (state_reg == fpl_pkg::FSM_IDLE);
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == fpl_pkg::FSM_READ) && (!m_valid_reg || m_ready);

    // Effective capacity: zero or above depth means full depth
    always_comb begin
        if (cap_reg == '0 || LIM_W'(cap_reg) > LIM_W'(STORE_DEPTH)) begin
            lim = LIM_W'(STORE_DEPTH);
        end else begin
            lim = LIM_W'(cap_reg);
        end
    end

    assign full      = LIM_W'(count_reg) >= lim;
    assign bad_pri   = {1'b0, s_priority_req} >= (fpl_pkg::PRI_W + 1)'(LEVEL_COUNT);
    assign empty     = (count_reg == '0);
    assign enq_ok    = (act == fpl_pkg::ACT_ENQ) && !full && !bad_pri;
    assign do_remove = (act == fpl_pkg::ACT_DEQ || act == fpl_pkg::ACT_DEQ_PRI) && !empty;
    assign req_lvl   = s_priority_req[LVL_W-1:0];

    // Find the highest level that holds entries
    always_comb begin
        top_lvl = '0;
        for (int l = 0; l < LEVEL_COUNT; l++) begin
            if (lcnt_reg[l] != '0) begin
                top_lvl = LVL_W'(l);
            end
        end
    end

    // Select the target slot: oldest overall, or oldest of the top level
    always_comb begin
        sel_idx = '0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (act == fpl_pkg::ACT_DEQ) begin
                sel_hot[i] = live_reg[i] && (grank_reg[i] == '0);
            end else begin
                sel_hot[i] = live_reg[i] && (lvl_reg[i] == top_lvl) && (lrank_reg[i] == '0);
            end
            if (sel_hot[i]) begin
                sel_idx = sel_idx | IDX_W'(i);
            end
        end
    end

    // Lowest free slot for an enqueue
    always_comb begin
        free_idx = '0;
        for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
            if (!live_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign rem_lvl   = lvl_reg[sel_idx];
    assign rem_grank = grank_reg[sel_idx];
    assign rem_lrank = lrank_reg[sel_idx];

    // Next slot bookkeeping: add on enqueue, drop and re-age on removal
    always_comb begin
        live_next  = live_reg;
        lvl_next   = lvl_reg;
        grank_next = grank_reg;
        lrank_next = lrank_reg;
        lcnt_next  = lcnt_reg;
        count_next = count_reg;
        if (accept && enq_ok) begin
            live_next[free_idx]  = 1'b1;
            lvl_next[free_idx]   = req_lvl;
            grank_next[free_idx] = count_reg[IDX_W-1:0];
            lrank_next[free_idx] = lcnt_reg[req_lvl][IDX_W-1:0];
            lcnt_next[req_lvl]   = lcnt_reg[req_lvl] + 1'b1;
            count_next           = count_reg + 1'b1;
        end else if (accept && do_remove) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                if (live_reg[i] && grank_reg[i] > rem_grank) begin
                    grank_next[i] = grank_reg[i] - 1'b1;
                end
                if (live_reg[i] && lvl_reg[i] == rem_lvl && lrank_reg[i] > rem_lrank) begin
                    lrank_next[i] = lrank_reg[i] - 1'b1;
                end
            end
            live_next[sel_idx] = 1'b0;
            lcnt_next[rem_lvl] = lcnt_reg[rem_lvl] - 1'b1;
            count_next         = count_reg - 1'b1;
        end
    end

    // Pending result fields captured at acceptance
    always_comb begin
        pst_next   = pst_reg;
        pzero_next = pzero_reg;
        pocc_next  = pocc_reg;
        if (accept) begin
            pocc_next  = fpl_pkg::OCC_W'(count_next);
            pzero_next = 1'b1;
            if (act == fpl_pkg::ACT_ENQ) begin
                if (full) begin
                    pst_next = fpl_pkg::ST_FULL;
                end else if (bad_pri) begin
                    pst_next = fpl_pkg::ST_BADPRI;
                end else begin
                    pst_next = fpl_pkg::ST_OK;
                end
            end else if (empty) begin
                pst_next = fpl_pkg::ST_EMPTY;
            end else begin
                pst_next   = fpl_pkg::ST_OK;
                pzero_next = 1'b0;
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fpl_pkg::FSM_IDLE: begin
                if (accept) begin
                    state_next = fpl_pkg::FSM_READ;
                end
            end
            fpl_pkg::FSM_READ: begin
                if (load_out) begin
                    state_next = fpl_pkg::FSM_IDLE;
                end
            end
            default: state_next = fpl_pkg::FSM_IDLE;
        endcase
    end

    // Value store
    fpl_ram #(
        .WIDTH (fpl_pkg::VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_values (
        .aclk  (aclk),
        .we    (accept && enq_ok),
        .waddr (free_idx),
        .wdata (s_value),
        .re    (accept),
        .raddr (sel_idx),
        .rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fpl_pkg::FSM_IDLE;
            live_reg    <= '0;
            count_reg   <= '0;
            cap_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int l = 0; l < LEVEL_COUNT; l++) begin
                lcnt_reg[l] <= '0;
            end
        end else begin
            state_reg <= state_next;
            live_reg  <= live_next;
            count_reg <= count_next;
            lcnt_reg  <= lcnt_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        lvl_reg   <= lvl_next;
        grank_reg <= grank_next;
        lrank_reg <= lrank_next;
        pst_reg   <= pst_next;
        pzero_reg <= pzero_next;
        pocc_reg  <= pocc_next;
        if (load_out) begin
            m_status_reg <= pst_reg;
            m_data_reg   <= pzero_reg ? '0 : ram_rdata;
            m_occ_reg    <= pocc_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_data_out  = m_data_reg;
    assign m_occupancy = m_occ_reg;

endmodule
